@@ hw/rtl/overwriting_log_ring_macros.svh @@
// assertion macros for the overwriting log ring checker
// no dependencies; pulled in by the checker file
`ifndef OVERWRITING_LOG_RING_MACROS_SVH
`define OVERWRITING_LOG_RING_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define OLR_ASSERT_NOW(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("olr check failed");

// next-cycle implication, disabled while reset is asserted
`define OLR_ASSERT_NEXT(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("olr check failed");

`endif

@@ hw/rtl/olr_pkg.sv @@
// types and codes shared by the overwriting log ring and its checker
// no dependencies
`default_nettype none

package olr_pkg;

	typedef enum logic [1:0] {
		CMD_APPEND    = 2'd0,
		CMD_SET_TAKEN = 2'd1,
		CMD_ARM       = 2'd2,
		CMD_DUMP      = 2'd3
	} cmd_t;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_BYTE   = 1'b1;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  data_byte;
		logic [31:0] taken_count;
	} item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] out_byte;
		logic       last;
		logic       irq_fire;
		logic       pending;
	} result_t;

endpackage

`default_nettype wire

@@ hw/rtl/overwriting_log_ring.sv @@
// overwriting log ring: byte ring memory, write/taken counters, interrupt arm
// depends on olr_pkg
`default_nettype none
//
// Usage:
//   An item is taken at a rising edge with start high and busy low. Append,
//   set-taken and arm each give one status result on the following cycle,
//   and busy stays low for them, so appends can stream one per cycle.
//   Dump reads the last min(untaken, LOG_SIZE) bytes from the ring memory,
//   oldest first, one per cycle; the first byte shows once the item has
//   passed the dump state and then the registered read port of the ring
//   memory, and busy is held until the last byte has been shown, so the
//   next item is taken only after the whole dump. The read port of the ring
//   memory does one read per cycle.
//   A dump with nothing untaken gives one status result the next cycle.
//   Every result is on result for exactly one cycle, marked by strobe; the
//   receiver cannot stall it.
//   Reset clears both counters, disarms the interrupt and clears a valid
//   flag per ring entry, so entries never written read back as zero; there
//   is no clearing pass and the block takes items right after reset.
//
module overwriting_log_ring
	import olr_pkg::*;
#(
	parameter int LOG_SIZE = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  item_t   item,
	output logic    busy,
	output logic    strobe,
	output result_t result
);

	localparam int AW = $clog2(LOG_SIZE);
	localparam int CW = $clog2(LOG_SIZE + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(LOG_SIZE - 1);
	// 2^32 mod LOG_SIZE, used when the start of a dump lies before a count wrap
	localparam logic [AW-1:0] WRAP_REM = AW'((64'd1 << 32) % LOG_SIZE);
	localparam logic [CW-1:0] SIZE_C = CW'(LOG_SIZE);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DUMP = 2'b10
	} state_t;

	function automatic logic is_pend(input logic [31:0] diff);
		return !diff[31] && (diff != 32'd0);
	endfunction

	function automatic logic [AW-1:0] step_idx(input logic [31:0] pos,
		input logic [AW-1:0] idx);
		return ((pos == 32'hFFFF_FFFF) || (idx == LAST_IDX)) ? '0 : idx + 1'b1;
	endfunction

	state_t               state_q;
	logic [31:0]          wr_count_q;
	logic [31:0]          taken_q;
	logic                 armed_q;
	logic [AW-1:0]        wr_idx_q;
	logic [LOG_SIZE-1:0]  valid_q;
	logic [CW-1:0]        remain_q;
	logic [AW-1:0]        rd_idx_q;
	logic [31:0]          rd_pos_q;
	logic                 dump_pend_q;
	logic                 stat_vld_q;
	result_t              stat_q;

	logic [7:0]           ring [LOG_SIZE];
	logic [7:0]           rd_byte_s1;
	logic                 rd_hit_s1;
	logic                 rd_last_s1;
	logic                 rd_vld_s1;

	logic                 accept;
	logic [31:0]          untaken;
	logic                 pend_now;
	logic [31:0]          wr_next;
	logic [CW-1:0]        dump_n;
	logic [AW+1:0]        base_w;
	logic [AW+1:0]        diff_w;
	logic [AW+1:0]        start_w;
	logic [AW-1:0]        start_idx;
	logic                 fire;
	logic                 pend_after;

	assign accept   = start && !busy;
	assign untaken  = wr_count_q - taken_q;
	assign pend_now = is_pend(untaken);
	assign wr_next  = wr_count_q + 32'd1;

	always_comb begin
		if (untaken[31]) begin
			dump_n = '0;
		end else if (untaken > 32'(LOG_SIZE)) begin
			dump_n = SIZE_C;
		end else begin
			dump_n = untaken[CW-1:0];
		end
	end

	// ring index of write_count - n; a start before the 2^32 wrap adds the wrap remainder
	always_comb begin
		if (wr_count_q < 32'(dump_n)) begin
			base_w = (AW+2)'(wr_idx_q) + (AW+2)'(WRAP_REM);
		end else begin
			base_w = (AW+2)'(wr_idx_q);
		end
		diff_w = base_w - (AW+2)'(dump_n);
		start_w = diff_w[AW+1] ? diff_w + (AW+2)'(LOG_SIZE) : diff_w;
		start_idx = start_w[AW-1:0];
	end

	always_comb begin
		fire = 1'b0;
		pend_after = pend_now;
		case (item.cmd)
			CMD_APPEND: begin
				fire = !pend_now && armed_q;
				pend_after = is_pend(wr_next - taken_q);
			end
			CMD_SET_TAKEN: begin
				pend_after = is_pend(wr_count_q - item.taken_count);
			end
			CMD_ARM: begin
				fire = pend_now;
			end
			default: begin
				fire = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wr_count_q <= '0;
			taken_q    <= '0;
			armed_q    <= 1'b0;
			wr_idx_q   <= '0;
			valid_q    <= '0;
			remain_q   <= '0;
			stat_vld_q <= 1'b0;
			rd_vld_s1  <= 1'b0;
		end else begin
			stat_vld_q <= 1'b0;
			rd_vld_s1  <= (state_q == ST_DUMP);
			if (accept) begin
				case (item.cmd)
					CMD_APPEND: begin
						wr_count_q        <= wr_next;
						wr_idx_q          <= step_idx(wr_count_q, wr_idx_q);
						valid_q[wr_idx_q] <= 1'b1;
						if (fire) begin
							armed_q <= 1'b0;
						end
						stat_vld_q <= 1'b1;
					end
					CMD_SET_TAKEN: begin
						taken_q    <= item.taken_count;
						stat_vld_q <= 1'b1;
					end
					CMD_ARM: begin
						armed_q    <= !pend_now;
						stat_vld_q <= 1'b1;
					end
					default: begin
						if (dump_n == '0) begin
							stat_vld_q <= 1'b1;
						end else begin
							state_q  <= ST_DUMP;
							remain_q <= dump_n;
						end
					end
				endcase
			end else if (state_q == ST_DUMP) begin
				remain_q <= remain_q - 1'b1;
				if (remain_q == CW'(1)) begin
					state_q <= ST_IDLE;
				end
			end
		end
	end

	// dump read pointer and status payload
	always_ff @(posedge clk) begin
		if (accept) begin
			stat_q.kind     <= KIND_STATUS;
			stat_q.out_byte <= '0;
			stat_q.last     <= 1'b1;
			stat_q.irq_fire <= fire;
			stat_q.pending  <= pend_after;
			rd_idx_q        <= start_idx;
			rd_pos_q        <= wr_count_q - 32'(dump_n);
			dump_pend_q     <= pend_now;
		end else if (state_q == ST_DUMP) begin
			rd_idx_q <= step_idx(rd_pos_q, rd_idx_q);
			rd_pos_q <= rd_pos_q + 32'd1;
		end
	end

	// ring memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (accept && (item.cmd == CMD_APPEND)) begin
			ring[wr_idx_q] <= item.data_byte;
		end
		rd_byte_s1 <= ring[rd_idx_q];
		rd_hit_s1  <= valid_q[rd_idx_q];
		rd_last_s1 <= (remain_q == CW'(1));
	end

	assign busy   = (state_q != ST_IDLE) || rd_vld_s1;
	assign strobe = stat_vld_q || rd_vld_s1;

	always_comb begin
		if (rd_vld_s1) begin
			result.kind     = KIND_BYTE;
			result.out_byte = rd_hit_s1 ? rd_byte_s1 : 8'd0;
			result.last     = rd_last_s1;
			result.irq_fire = 1'b0;
			result.pending  = dump_pend_q;
		end else begin
			result = stat_q;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/olr_checker.sv @@
// port-level checks for the overwriting log ring, bound into every overwriting_log_ring instance
// depends on olr_pkg and overwriting_log_ring_macros.svh
`default_nettype none
`include "overwriting_log_ring_macros.svh"

module olr_checker
	import olr_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    start,
	input wire item_t   item,
	input wire logic    busy,
	input wire logic    strobe,
	input wire result_t result
);

	logic byte_mid;
	logic cmd_taken;

	assign byte_mid  = strobe && (result.kind == KIND_BYTE) && !result.last;
	assign cmd_taken = start && !busy && (item.cmd != CMD_DUMP);

	// a status result always closes its item
	`OLR_ASSERT_NOW(a_status_last, clk, arst_n, strobe && (result.kind == KIND_STATUS), result.last)
	// dumped bytes never carry the interrupt
	`OLR_ASSERT_NOW(a_byte_no_irq, clk, arst_n, strobe && (result.kind == KIND_BYTE), !result.irq_fire)
	// a dump in progress keeps the block busy
	`OLR_ASSERT_NOW(a_dump_busy, clk, arst_n, byte_mid, busy)
	// dump bytes come back to back until the last one
	`OLR_ASSERT_NEXT(a_dump_run, clk, arst_n, byte_mid, strobe && (result.kind == KIND_BYTE))
	// any item other than a dump answers with a status result the next cycle
	`OLR_ASSERT_NEXT(a_cmd_status, clk, arst_n, cmd_taken, strobe && (result.kind == KIND_STATUS))

endmodule

bind overwriting_log_ring olr_checker u_olr_checker (.*);

`default_nettype wire

@@ test/tb_top.sv @@
// testbench for overwriting_log_ring: checks every result against an in-bench model
// of the byte ring, counters and interrupt arm; depends on olr_pkg and the ring rtl
`default_nettype none

module tb_top;
	import olr_pkg::*;

	localparam int RING_DEPTH = 64;
	localparam int unsigned TOTAL_ITEMS = 450;
	localparam int unsigned STALL_LIMIT = 400;
	localparam int unsigned TAIL_CYCLES = 80;
	localparam int unsigned PRINT_LIMIT = 40;

	typedef struct {
		item_t       it;
		int unsigned gap;
	} queued_item_t;

	typedef struct {
		result_t     res;
		int unsigned item_no;
	} due_result_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	item_t   item = '0;
	logic    busy;
	logic    strobe;
	result_t result;

	overwriting_log_ring #(
		.LOG_SIZE(RING_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.strobe(strobe),
		.result(result)
	);

	// model state
	logic [7:0]  ring_mem [RING_DEPTH];
	logic [31:0] ring_writes;
	logic [31:0] reader_mark;
	logic        model_armed;

	queued_item_t item_backlog [$];
	due_result_t  due_results [$];
	queued_item_t next_up;
	due_result_t  want;

	int unsigned accept_count = 0;
	int unsigned wait_left = 0;
	int unsigned stall_cycles = 0;
	int unsigned error_count = 0;
	int unsigned calm_left = 0;
	logic [31:0] gen_writes = '0;

	initial forever #10 clk = ~clk;

	task automatic flag_error(input string msg);
		if (error_count < PRINT_LIMIT)
			$display("error: %s", msg);
		error_count++;
	endtask

	// negative signed distance means the reader is ahead, so nothing is unread
	function automatic logic [31:0] unread_bytes();
		logic [31:0] d;
		d = ring_writes - reader_mark;
		return d[31] ? 32'd0 : d;
	endfunction

	task automatic push_due(input logic kind, input logic [7:0] b, input logic last,
			input logic fire, input logic pend, input int unsigned item_no);
		due_result_t r;
		r.res.kind = kind;
		r.res.out_byte = b;
		r.res.last = last;
		r.res.irq_fire = fire;
		r.res.pending = pend;
		r.item_no = item_no;
		due_results.push_back(r);
	endtask

	task automatic model_item(input item_t it, input int unsigned item_no);
		logic        fire;
		logic        quiet;
		logic        pend;
		logic [31:0] n;
		logic [31:0] idx;
		fire = 1'b0;
		case (it.cmd)
			CMD_APPEND: begin
				quiet = (unread_bytes() == 0);
				ring_mem[ring_writes % RING_DEPTH] = it.data_byte;
				ring_writes = ring_writes + 1;
				if (quiet && model_armed) begin
					fire = 1'b1;
					model_armed = 1'b0;
				end
			end
			CMD_SET_TAKEN: begin
				reader_mark = it.taken_count;
			end
			CMD_ARM: begin
				model_armed = 1'b1;
				if (unread_bytes() != 0) begin
					fire = 1'b1;
					model_armed = 1'b0;
				end
			end
			default: begin
				n = unread_bytes();
				pend = (n != 0);
				if (n > RING_DEPTH)
					n = RING_DEPTH;
				if (n == 0) begin
					push_due(KIND_STATUS, 8'h00, 1'b1, 1'b0, pend, item_no);
				end else begin
					for (idx = ring_writes - n; idx != ring_writes; idx++)
						push_due(KIND_BYTE, ring_mem[idx % RING_DEPTH],
							idx + 1 == ring_writes, 1'b0, pend, item_no);
				end
				return;
			end
		endcase
		push_due(KIND_STATUS, 8'h00, 1'b1, fire, unread_bytes() != 0, item_no);
	endtask

	// gaps come in random runs with calm stretches of back-to-back items
	task automatic queue_item(input cmd_t c, input logic [7:0] b, input logic [31:0] t);
		queued_item_t q;
		q.it.cmd = c;
		q.it.data_byte = b;
		q.it.taken_count = t;
		if (calm_left != 0) begin
			calm_left--;
			q.gap = 0;
		end else begin
			if ($urandom_range(0, 7) == 0)
				calm_left = $urandom_range(8, 30);
			q.gap = $urandom_range(0, 9);
		end
		if (c == CMD_APPEND)
			gen_writes = gen_writes + 1;
		item_backlog.push_back(q);
	endtask

	task automatic queue_random_items();
		int unsigned pick;
		int unsigned burst;
		while (item_backlog.size() < TOTAL_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				burst = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
					: $urandom_range(1, 12);
				repeat (burst)
					if (item_backlog.size() < TOTAL_ITEMS)
						queue_item(CMD_APPEND, 8'($urandom), 32'($urandom));
			end else if (pick < 60) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4:
						queue_item(CMD_SET_TAKEN, 8'($urandom),
							gen_writes - $urandom_range(0, 70));
					5: queue_item(CMD_SET_TAKEN, 8'($urandom),
							gen_writes + $urandom_range(1, 4));
					6: queue_item(CMD_SET_TAKEN, 8'($urandom), 32'($urandom));
					7: queue_item(CMD_SET_TAKEN, 8'($urandom),
							gen_writes - 32'h8000_0000 + $urandom_range(0, 1));
					8: queue_item(CMD_SET_TAKEN, 8'($urandom),
							$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
					default: queue_item(CMD_SET_TAKEN, 8'($urandom), gen_writes);
				endcase
			end else if (pick < 72) begin
				queue_item(CMD_ARM, 8'($urandom), 32'($urandom));
			end else if (pick < 90) begin
				queue_item(CMD_DUMP, 8'($urandom), 32'($urandom));
			end else begin
				queue_item(cmd_t'($urandom_range(0, 3)), 8'($urandom), 32'($urandom));
			end
		end
	endtask

	// driver: the item on the bus is taken at an edge with start high and busy low
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			wait_left <= 0;
		end else begin
			if (start && !busy) begin
				model_item(item, accept_count);
				accept_count <= accept_count + 1;
			end
			if (!start || !busy) begin
				if (wait_left != 0) begin
					wait_left <= wait_left - 1;
					start <= 1'b0;
				end else if (item_backlog.size() != 0) begin
					next_up = item_backlog.pop_front();
					item <= next_up.it;
					start <= 1'b1;
					wait_left <= next_up.gap;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every strobed result is matched against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (due_results.size() == 0) begin
				flag_error($sformatf("unexpected result %p", result));
			end else begin
				want = due_results.pop_front();
				if (want.item_no >= accept_count)
					flag_error($sformatf("item %0d: result came with the item", want.item_no));
				if (result.kind !== want.res.kind)
					flag_error($sformatf("item %0d: kind %b, want %b",
						want.item_no, result.kind, want.res.kind));
				if (result.out_byte !== want.res.out_byte)
					flag_error($sformatf("item %0d: out_byte %h, want %h",
						want.item_no, result.out_byte, want.res.out_byte));
				if (result.last !== want.res.last)
					flag_error($sformatf("item %0d: last %b, want %b",
						want.item_no, result.last, want.res.last));
				if (result.irq_fire !== want.res.irq_fire)
					flag_error($sformatf("item %0d: irq_fire %b, want %b",
						want.item_no, result.irq_fire, want.res.irq_fire));
				if (result.pending !== want.res.pending)
					flag_error($sformatf("item %0d: pending %b, want %b",
						want.item_no, result.pending, want.res.pending));
			end
		end
	end

	// watchdog: cycles with neither an item nor a result taken
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		for (int i = 0; i < RING_DEPTH; i++)
			ring_mem[i] = 8'h00;
		ring_writes = '0;
		reader_mark = '0;
		model_armed = 1'b0;

		queue_item(CMD_DUMP, 8'h00, 32'h0);            // dump with nothing untaken
		queue_item(CMD_ARM, 8'h00, 32'h0);
		queue_item(CMD_APPEND, 8'h00, 32'hFFFF_FFFF);  // fires from quiet
		queue_item(CMD_APPEND, 8'hFF, 32'h0);
		queue_item(CMD_ARM, 8'hFF, 32'h0);             // arm finds pending set
		queue_item(CMD_ARM, 8'h00, 32'hFFFF_FFFF);
		queue_item(CMD_DUMP, 8'hFF, 32'hFFFF_FFFF);
		queue_item(CMD_SET_TAKEN, 8'hFF, 32'd2);
		queue_item(CMD_ARM, 8'h00, 32'h0);
		queue_item(CMD_ARM, 8'h00, 32'h0);             // arm while armed
		queue_item(CMD_SET_TAKEN, 8'h00, 32'd5);       // taken ahead of writes
		queue_item(CMD_APPEND, 8'hA5, 32'h0);          // fires, pending stays low
		queue_item(CMD_DUMP, 8'h00, 32'h0);
		queue_item(CMD_SET_TAKEN, 8'h00, 32'hFFFF_FFC3); // full ring incl. unwritten
		queue_item(CMD_DUMP, 8'h00, 32'h0);
		queue_item(CMD_SET_TAKEN, 8'h00, 32'h8000_0003); // distance on the sign bit
		queue_item(CMD_DUMP, 8'h00, 32'h0);
		queue_item(CMD_SET_TAKEN, 8'h00, 32'h8000_0004); // largest positive distance
		queue_item(CMD_DUMP, 8'h00, 32'h0);
		queue_item(CMD_SET_TAKEN, 8'h00, 32'hFFFF_FFFF); // wraps below index zero
		queue_item(CMD_DUMP, 8'h00, 32'h0);
		queue_random_items();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (!(accept_count == TOTAL_ITEMS && due_results.size() == 0)
				&& stall_cycles < STALL_LIMIT)
			@(posedge clk);
		if (stall_cycles >= STALL_LIMIT) begin
			flag_error($sformatf("no progress for %0d cycles, %0d items taken",
				STALL_LIMIT, accept_count));
		end else begin
			repeat (TAIL_CYCLES) @(posedge clk);
			if (due_results.size() != 0)
				flag_error($sformatf("%0d results never came", due_results.size()));
		end

		if (error_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
